// ===== hdl/lpa_pkg.sv =====
`timescale 1ns / 1ps
package lpa_pkg;

  // configuration port
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // register fields
  localparam int unsigned SF_W  = 4;
  localparam int unsigned BWC_W = 4;
  localparam int unsigned CR_W  = 3;
  localparam int unsigned PRE_W = 16;
  localparam int unsigned BW_W  = 19;

  // register reset values
  localparam logic [SF_W-1:0]  SF_RST  = 4'd7;
  localparam logic [BWC_W-1:0] BWC_RST = 4'd0;
  localparam logic [CR_W-1:0]  CR_RST  = 3'd1;
  localparam logic [PRE_W-1:0] PRE_RST = 16'd8;

  // valid ranges of the registers
  localparam logic [SF_W-1:0]  SF_MIN  = 4'd5;
  localparam logic [SF_W-1:0]  SF_MAX  = 4'd12;
  localparam logic [BWC_W-1:0] BWC_MAX = 4'd9;
  localparam logic [CR_W-1:0]  CR_MIN  = 3'd1;
  localparam logic [CR_W-1:0]  CR_MAX  = 3'd4;

  // datapath widths
  localparam int unsigned PL_W    = 8;   // payload length
  localparam int unsigned SDIV_W  = 10;  // payload symbol dividend
  localparam int unsigned SQUO_W  = 8;   // payload symbol blocks
  localparam int unsigned QTR_W   = 19;  // quarter-symbol count
  localparam int unsigned SCL_W   = 27;  // quarter-symbols times ms scale
  localparam int unsigned NUM_W   = 39;  // time dividend
  localparam int unsigned TQUO_W  = 27;  // time quotient
  localparam int unsigned MS_W    = 26;  // airtime output

  // 1000 ms per second over four quarter-symbols
  localparam logic [SCL_W-1:0] MS_SCALE = 27'd250;
  localparam logic [MS_W-1:0]  MS_MAX   = 26'd67108863;

  // register map
  typedef enum logic [1:0] {
    REG_SF  = 2'd0,
    REG_BW  = 2'd1,
    REG_CR  = 2'd2,
    REG_PRE = 2'd3
  } lpa_reg_e;

  // effective configuration, already clamped
  typedef struct packed {
    logic [SF_W-1:0]  sf;
    logic [SF_W-1:0]  k;     // spreading factor less twice the ldro flag
    logic [CR_W-1:0]  cr;
    logic [PRE_W-1:0] pre;
    logic [BW_W-1:0]  bw;
    logic             ldro;
  } lpa_cfg_t;

  // bandwidth in hz per code
  function automatic logic [BW_W-1:0] bw_hz(input logic [BWC_W-1:0] code);
    logic [BW_W-1:0] hz;
    case (code)
      4'd0:    hz = 19'd125000;
      4'd1:    hz = 19'd250000;
      4'd2:    hz = 19'd500000;
      4'd3:    hz = 19'd62500;
      4'd4:    hz = 19'd41670;
      4'd5:    hz = 19'd31250;
      4'd6:    hz = 19'd20830;
      4'd7:    hz = 19'd15630;
      4'd8:    hz = 19'd10420;
      default: hz = 19'd7810;
    endcase
    return hz;
  endfunction

  // smallest spreading factor whose symbol exceeds 16.38 ms at this bandwidth
  function automatic logic [SF_W-1:0] ldro_min_sf(input logic [BWC_W-1:0] code);
    logic [SF_W-1:0] sf;
    case (code)
      4'd0:    sf = 4'd11;
      4'd1:    sf = 4'd12;
      4'd2:    sf = 4'd13;  // never reached
      4'd3:    sf = 4'd10;
      4'd4:    sf = 4'd10;
      4'd5:    sf = 4'd9;
      4'd6:    sf = 4'd9;
      4'd7:    sf = 4'd9;
      4'd8:    sf = 4'd8;
      default: sf = 4'd7;
    endcase
    return sf;
  endfunction

endpackage

// ===== hdl/lpa_cfg_regs.sv =====
`timescale 1ns / 1ps
module lpa_cfg_regs import lpa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [DATA_W-1:0] pwdata_i,
  output logic [DATA_W-1:0] prdata_o,
  output logic              pready_o,
  output lpa_cfg_t          cfg_o
);

  logic [SF_W-1:0]  sf_q;
  logic [BWC_W-1:0] bwc_q;
  logic [CR_W-1:0]  cr_q;
  logic [PRE_W-1:0] pre_q;
  lpa_reg_e         reg_sel;
  logic             wr_en;
  logic [SF_W-1:0]  sf_eff;
  logic [BWC_W-1:0] bwc_eff;
  logic [CR_W-1:0]  cr_eff;
  logic             ldro;

  assign reg_sel  = lpa_reg_e'(paddr_i[ADDR_W-1:2]);
  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign pready_o = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sf_q  <= SF_RST;
      bwc_q <= BWC_RST;
      cr_q  <= CR_RST;
      pre_q <= PRE_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_SF:  sf_q  <= pwdata_i[SF_W-1:0];
        REG_BW:  bwc_q <= pwdata_i[BWC_W-1:0];
        REG_CR:  cr_q  <= pwdata_i[CR_W-1:0];
        REG_PRE: pre_q <= pwdata_i[PRE_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_sel)
      REG_SF:  prdata_o = DATA_W'(sf_q);
      REG_BW:  prdata_o = DATA_W'(bwc_q);
      REG_CR:  prdata_o = DATA_W'(cr_q);
      REG_PRE: prdata_o = DATA_W'(pre_q);
      default: prdata_o = '0;
    endcase
  end

  // clamp out-of-range settings
  always_comb begin
    sf_eff = sf_q;
    if (sf_q < SF_MIN) sf_eff = SF_MIN;
    if (sf_q > SF_MAX) sf_eff = SF_MAX;
    bwc_eff = (bwc_q > BWC_MAX) ? BWC_MAX : bwc_q;
    cr_eff = cr_q;
    if (cr_q < CR_MIN) cr_eff = CR_MIN;
    if (cr_q > CR_MAX) cr_eff = CR_MAX;
  end

  // low data rate optimisation and derived values
  assign ldro      = (sf_eff >= ldro_min_sf(bwc_eff));
  assign cfg_o.sf   = sf_eff;
  assign cfg_o.k    = ldro ? (sf_eff - SF_W'(2)) : sf_eff;
  assign cfg_o.cr   = cr_eff;
  assign cfg_o.pre  = pre_q;
  assign cfg_o.bw   = bw_hz(bwc_eff);
  assign cfg_o.ldro = ldro;

endmodule

// ===== hdl/lpa_div_cell.sv =====
`timescale 1ns / 1ps
module lpa_div_cell #(
  parameter int unsigned REM_W = 10,
  parameter int unsigned DIV_W = 4,
  parameter int unsigned QUO_W = 8,
  parameter int unsigned SHIFT = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [REM_W-1:0] rem_i,
  input  logic [QUO_W-1:0] quo_i,
  input  logic [DIV_W-1:0] div_i,
  output logic             valid_o,
  output logic [REM_W-1:0] rem_o,
  output logic [QUO_W-1:0] quo_o
);

  localparam int unsigned CMP_W = (REM_W > DIV_W + QUO_W) ? REM_W : DIV_W + QUO_W;

  logic [CMP_W-1:0] rem_x;
  logic [CMP_W-1:0] div_sh;
  logic             take;
  logic [REM_W-1:0] rem_d;
  logic [QUO_W-1:0] quo_d;

  // one restoring step: trial subtract of the shifted divisor
  always_comb begin
    rem_x  = CMP_W'(rem_i);
    div_sh = CMP_W'(div_i) << SHIFT;
    take   = (rem_x >= div_sh);
    rem_d  = take ? REM_W'(rem_x - div_sh) : rem_i;
    quo_d  = quo_i;
    quo_d[SHIFT] = take;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      quo_o <= quo_d;
    end
  end

endmodule

// ===== hdl/lpa_div_chain.sv =====
`timescale 1ns / 1ps
module lpa_div_chain #(
  parameter int unsigned REM_W = 10,
  parameter int unsigned DIV_W = 4,
  parameter int unsigned QUO_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [REM_W-1:0] dividend_i,
  input  logic [DIV_W-1:0] divisor_i,
  output logic             valid_o,
  output logic [QUO_W-1:0] quotient_o
);

  logic             link_valid [QUO_W+1];
  logic [REM_W-1:0] link_rem   [QUO_W+1];
  logic [QUO_W-1:0] link_quo   [QUO_W+1];

  assign link_valid[0] = valid_i;
  assign link_rem[0]   = dividend_i;
  assign link_quo[0]   = '0;

  // one quotient bit per cell, most significant first
  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    lpa_div_cell #(
      .REM_W (REM_W),
      .DIV_W (DIV_W),
      .QUO_W (QUO_W),
      .SHIFT (QUO_W - 1 - i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (link_valid[i]),
      .rem_i   (link_rem[i]),
      .quo_i   (link_quo[i]),
      .div_i   (divisor_i),
      .valid_o (link_valid[i+1]),
      .rem_o   (link_rem[i+1]),
      .quo_o   (link_quo[i+1])
    );
  end

  assign valid_o    = link_valid[QUO_W];
  assign quotient_o = link_quo[QUO_W];

endmodule

// ===== hdl/lora_packet_airtime.sv =====
`timescale 1ns / 1ps
// lora packet time on air
// input channel (in_valid_i / in_ready_o) takes one payload length per item;
// output channel (out_valid_o / out_ready_i) returns the rounded time on air
// in ms and the low data rate optimisation flag, one result per item, in order.
// spreading factor, bandwidth, coding rate and preamble length are set over the
// apb port at byte addresses 0, 4, 8 and 12; the user must write them only
// while no item is in flight, as the block itself does not enforce it.
// throughput: one item per cycle while in_ready_o is high. the work runs
// through a row of long division cells, 8 for the payload symbol count and 27
// for the final division by the bandwidth, one quotient bit per cell, with two
// arithmetic stages between them and an output register at the end.
// when the receiver stalls, the output register holds its result and a skid
// register catches the next one; in_ready_o drops only once the skid register
// is full, and the whole row then holds until the output is taken.
// reset empties the pipeline and restores the register defaults
// (sf 7, 125 khz, coding rate 4/5, preamble 8).
module lora_packet_airtime import lpa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [PL_W-1:0]   payload_bytes_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [MS_W-1:0]   airtime_ms_o,
  output logic              low_rate_opt_o
);

  lpa_cfg_t          cfg;
  logic              en;
  logic              in_acc;
  logic [11:0]       num_t;
  logic [11:0]       num_s;
  logic [11:0]       num_n;
  logic [12:0]       num_r;
  logic              num_pos;
  logic [SDIV_W-1:0] sym_div;
  logic              sym_valid;
  logic [SQUO_W-1:0] sym_quo;
  logic [11:0]       pay_prod;
  logic [10:0]       pay_sym;
  logic [QTR_W-1:0]  qtr_d;
  logic              qtr_valid_q;
  logic [QTR_W-1:0]  qtr_q;
  logic              scl_valid_q;
  logic [SCL_W-1:0]  scl_q;
  logic [NUM_W-1:0]  tm_div;
  logic              tm_valid;
  logic [TQUO_W-1:0] tm_quo;
  logic [MS_W-1:0]   ms_sat;
  logic              out_valid_q;
  logic [MS_W-1:0]   out_ms_q;
  logic              out_ldro_q;
  logic              skid_valid_q;
  logic [MS_W-1:0]   skid_ms_q;
  logic              skid_ldro_q;
  logic              arrive;

  lpa_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  // the row advances while the skid register is free
  assign en         = !skid_valid_q;
  assign in_ready_o = en;
  assign in_acc     = in_valid_i && en;

  // payload symbol dividend: ceil(num / 4k) as ceil(ceil(num / 4) / k)
  always_comb begin
    num_t   = 12'({payload_bytes_i, 3'b000}) + 12'd44;
    num_s   = 12'({cfg.sf, 2'b00});
    num_pos = (num_t > num_s);
    num_n   = num_t - num_s;
    num_r   = 13'(num_n) + 13'd3;
    sym_div = num_pos ? (SDIV_W'(num_r[12:2]) + SDIV_W'(cfg.k) - SDIV_W'(1)) : '0;
  end

  lpa_div_chain #(
    .REM_W (SDIV_W),
    .DIV_W (SF_W),
    .QUO_W (SQUO_W)
  ) u_sym_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_acc),
    .dividend_i (sym_div),
    .divisor_i  (cfg.k),
    .valid_o    (sym_valid),
    .quotient_o (sym_quo)
  );

  // quarter-symbol count of the whole packet
  always_comb begin
    pay_prod = 12'(sym_quo) * 12'(CR_W'(cfg.cr) + 4'd4);
    pay_sym  = 11'(pay_prod) + 11'd8;
    qtr_d    = QTR_W'({cfg.pre, 2'b00}) + QTR_W'(17) + QTR_W'({pay_sym, 2'b00});
  end

  // quarter-symbol and scale stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qtr_valid_q <= 1'b0;
      scl_valid_q <= 1'b0;
    end else if (en) begin
      qtr_valid_q <= sym_valid;
      scl_valid_q <= qtr_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qtr_q <= qtr_d;
      scl_q <= SCL_W'(qtr_q) * MS_SCALE;
    end
  end

  // chips per symbol and half a bandwidth for round to nearest
  assign tm_div = (NUM_W'(scl_q) << cfg.sf) + NUM_W'(cfg.bw >> 1);

  lpa_div_chain #(
    .REM_W (NUM_W),
    .DIV_W (BW_W),
    .QUO_W (TQUO_W)
  ) u_time_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (scl_valid_q),
    .dividend_i (tm_div),
    .divisor_i  (cfg.bw),
    .valid_o    (tm_valid),
    .quotient_o (tm_quo)
  );

  assign ms_sat = tm_quo[TQUO_W-1] ? MS_MAX : tm_quo[MS_W-1:0];
  assign arrive = tm_valid && en;

  // output register with skid register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= arrive;
      end
    end else if (arrive) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_ms_q   <= skid_ms_q;
        out_ldro_q <= skid_ldro_q;
      end else begin
        out_ms_q   <= ms_sat;
        out_ldro_q <= cfg.ldro;
      end
    end else if (arrive) begin
      skid_ms_q   <= ms_sat;
      skid_ldro_q <= cfg.ldro;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign airtime_ms_o   = out_ms_q;
  assign low_rate_opt_o = out_ldro_q;

endmodule
